// ===== rtl/fpa_pkg.sv =====
package fpa_pkg;

    localparam int PAGE_COUNT_DEF = 16;
    localparam int PAGE_BYTES_DEF = 64;

    typedef enum logic [1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_CLEAR = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_OOB     = 2'd2
    } t_status;

endpackage

// ===== rtl/fpa_map.sv =====
module fpa_map
    import fpa_pkg::*;
#(
    parameter int PAGE_COUNT = PAGE_COUNT_DEF,
    localparam int AW = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic          i_wr_data,
    input  logic          i_clear_all,
    output logic          o_rd_used
);

    logic                  r_mem [PAGE_COUNT];
    logic [PAGE_COUNT-1:0] r_valid;
    logic                  r_rd_data;
    logic                  r_rd_valid;

    // An entry that has not been written since reset or the last clear reads as free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_clear_all) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data  <= r_mem[i_rd_addr];
            r_rd_valid <= r_valid[i_rd_addr];
        end
    end

    assign o_rd_used = r_rd_data & r_rd_valid;

endmodule

// ===== rtl/first_fit_page_allocator_top.sv =====
// A rejected request or cmd 3 is answered straight from idle, with o_done registered in the
// cycle after it is accepted. Free, clear and an allocate that finds no run scan the map, and
// an allocate that finds a run then marks its pages one per cycle.
// One request at a time through the map's single read port; start is only taken while idle.
// The result strobe o_done is high for one cycle; the receiver cannot stall it.
// Synchronous active-low reset frees every page at once through per-page valid bits.
module first_fit_page_allocator_top
    import fpa_pkg::*;
#(
    parameter int PAGE_COUNT = PAGE_COUNT_DEF,
    parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_cmd,
    input  logic [15:0] i_request_bytes,
    input  logic [15:0] i_release_offset,
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic [9:0]  o_base_offset,
    output logic [4:0]  o_pages_touched
);

    localparam int AW        = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam int PW        = AW + 1;
    localparam int MEM_BYTES = PAGE_COUNT * PAGE_BYTES;
    localparam int BW        = $clog2(MEM_BYTES + 1);
    localparam int CW        = (BW > 16) ? BW : 16;
    localparam int OBW       = (BW > 10) ? BW : 10;
    localparam int OTW       = (PW > 5) ? PW : 5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_MARK,
        S_FREE,
        S_CLEAR
    } t_state;

    t_state         r_state;
    logic           r_done;
    t_status        r_status;
    logic [BW-1:0]  r_base;
    logic [PW-1:0]  r_touched;

    logic [15:0]    r_req;
    logic [15:0]    r_off;
    logic [PW-1:0]  r_rd_page;
    logic [BW-1:0]  r_rd_base;
    logic           r_ev_live;
    logic [PW-1:0]  r_ev_page;
    logic [BW-1:0]  r_ev_base;
    logic [PW-1:0]  r_run_len;
    logic [BW-1:0]  r_run_bytes;
    logic [PW-1:0]  r_run_page;
    logic [BW-1:0]  r_run_base;
    logic [PW-1:0]  r_mark_page;
    logic [PW-1:0]  r_mark_left;

    logic           rd_en;
    logic           rd_more;
    logic [AW-1:0]  wr_addr;
    logic           wr_en;
    logic           wr_data;
    logic           clr_all;
    logic           ev_used;
    logic [BW-1:0]  ev_next_base;
    logic [BW-1:0]  run_bytes_inc;
    logic [PW-1:0]  run_len_inc;
    logic           run_hit;
    logic           free_skip;
    logic           alloc_reject;
    logic           free_oob;
    logic [OBW-1:0] base_ext;
    logic [OTW-1:0] touched_ext;

    assign rd_more       = r_rd_page < PW'(PAGE_COUNT);
    assign ev_next_base  = r_ev_base + BW'(PAGE_BYTES);
    assign run_bytes_inc = r_run_bytes + BW'(PAGE_BYTES);
    assign run_len_inc   = r_run_len + PW'(1);
    assign run_hit       = CW'(run_bytes_inc) >= CW'(r_req);
    // Pages that end at or before the release offset lie ahead of the page to free.
    assign free_skip     = CW'(ev_next_base) <= CW'(r_off);
    assign alloc_reject  = (i_request_bytes == 16'd0) ||
                           (CW'(i_request_bytes) > CW'(MEM_BYTES));
    assign free_oob      = CW'(i_release_offset) >= CW'(MEM_BYTES);

    always_comb begin
        rd_en   = 1'b0;
        wr_en   = 1'b0;
        wr_addr = r_ev_page[AW-1:0];
        wr_data = 1'b0;
        clr_all = 1'b0;
        case (r_state)
            S_SCAN: begin
                rd_en = rd_more;
            end
            S_MARK: begin
                wr_en   = 1'b1;
                wr_addr = r_mark_page[AW-1:0];
                wr_data = 1'b1;
            end
            S_FREE: begin
                rd_en = rd_more;
                wr_en = r_ev_live && !free_skip && ev_used;
            end
            S_CLEAR: begin
                rd_en   = rd_more;
                clr_all = !r_ev_live && !rd_more;
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    fpa_map #(
        .PAGE_COUNT(PAGE_COUNT)
    ) u_map (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (rd_en),
        .i_rd_addr  (r_rd_page[AW-1:0]),
        .i_wr_en    (wr_en),
        .i_wr_addr  (wr_addr),
        .i_wr_data  (wr_data),
        .i_clear_all(clr_all),
        .o_rd_used  (ev_used)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_done    <= 1'b0;
            r_ev_live <= 1'b0;
        end else begin
            r_done    <= 1'b0;
            r_ev_live <= rd_en;
            // Page p is evaluated the cycle after its read while page p+1 is being read.
            if (rd_en) begin
                r_ev_page <= r_rd_page;
                r_ev_base <= r_rd_base;
                r_rd_page <= r_rd_page + PW'(1);
                r_rd_base <= r_rd_base + BW'(PAGE_BYTES);
            end
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_rd_page   <= '0;
                        r_rd_base   <= '0;
                        r_run_len   <= '0;
                        r_run_bytes <= '0;
                        r_run_page  <= '0;
                        r_run_base  <= '0;
                        r_req       <= i_request_bytes;
                        r_off       <= i_release_offset;
                        r_touched   <= '0;
                        r_base      <= '0;
                        r_status    <= ST_OK;
                        case (t_cmd'(i_cmd))
                            CMD_ALLOC: begin
                                if (alloc_reject) begin
                                    r_status <= ST_NOSPACE;
                                    r_done   <= 1'b1;
                                end else begin
                                    r_state <= S_SCAN;
                                end
                            end
                            CMD_FREE: begin
                                if (free_oob) begin
                                    r_status <= ST_OOB;
                                    r_done   <= 1'b1;
                                end else begin
                                    r_state <= S_FREE;
                                end
                            end
                            CMD_CLEAR: begin
                                r_state <= S_CLEAR;
                            end
                            default: begin
                                r_done <= 1'b1;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (r_ev_live) begin
                        if (ev_used) begin
                            r_run_len   <= '0;
                            r_run_bytes <= '0;
                            r_run_page  <= r_ev_page + PW'(1);
                            r_run_base  <= ev_next_base;
                        end else if (run_hit) begin
                            r_mark_page <= r_run_page;
                            r_mark_left <= run_len_inc;
                            r_touched   <= run_len_inc;
                            r_base      <= r_run_base;
                            r_state     <= S_MARK;
                        end else begin
                            r_run_len   <= run_len_inc;
                            r_run_bytes <= run_bytes_inc;
                        end
                    end else if (!rd_more) begin
                        r_status <= ST_NOSPACE;
                        r_done   <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                S_MARK: begin
                    r_mark_page <= r_mark_page + PW'(1);
                    r_mark_left <= r_mark_left - PW'(1);
                    if (r_mark_left == PW'(1)) begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_FREE: begin
                    if (r_ev_live) begin
                        if (!free_skip) begin
                            if (ev_used) begin
                                r_touched <= r_touched + PW'(1);
                            end else begin
                                r_done  <= 1'b1;
                                r_state <= S_IDLE;
                            end
                        end
                    end else if (!rd_more) begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_CLEAR: begin
                    if (r_ev_live) begin
                        if (ev_used) begin
                            r_touched <= r_touched + PW'(1);
                        end
                    end else if (!rd_more) begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign base_ext    = OBW'(r_base);
    assign touched_ext = OTW'(r_touched);

    assign busy            = (r_state != S_IDLE);
    assign o_done          = r_done;
    assign o_status        = r_status;
    assign o_base_offset   = base_ext[9:0];
    assign o_pages_touched = touched_ext[4:0];

endmodule

// ===== test/first_fit_page_allocator_top_test.sv =====
module first_fit_page_allocator_top_test;
    import fpa_pkg::*;

    localparam int PAGES      = PAGE_COUNT_DEF;
    localparam int PAGE_SZ    = PAGE_BYTES_DEF;
    localparam int MEM_BYTES  = PAGES * PAGE_SZ;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0] status;
        logic [9:0] base;
        logic [4:0] touched;
    } t_page_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_cmd = CMD_ALLOC;
    logic [15:0] i_request_bytes = '0;
    logic [15:0] i_release_offset = '0;
    logic        o_done;
    logic [1:0]  o_status;
    logic [9:0]  o_base_offset;
    logic [4:0]  o_pages_touched;

    logic [PAGES-1:0] page_used = '0;
    t_page_result     pending_results[$];
    int               error_count = 0;
    int               cycle_count = 0;
    bit               no_gaps = 1'b0;

    first_fit_page_allocator_top u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_cmd            (i_cmd),
        .i_request_bytes  (i_request_bytes),
        .i_release_offset (i_release_offset),
        .o_done           (o_done),
        .o_status         (o_status),
        .o_base_offset    (o_base_offset),
        .o_pages_touched  (o_pages_touched)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        $display("MISMATCH %s: got %0d, expected %0d (cycle %0d)", what, got, want, cycle_count);
    endtask

    // Applies one request to the page map and returns the result it must produce.
    function automatic t_page_result apply_page_request(input logic [1:0] cmd,
                                                         input logic [15:0] bytes,
                                                         input logic [15:0] offset);
        t_page_result r;
        int unsigned  need;
        int unsigned  run;
        int unsigned  first;
        int           p;
        bit           found;
        r = '0;
        r.status = ST_OK;
        found = 1'b0;
        run = 0;
        first = 0;
        case (cmd)
            CMD_ALLOC: begin
                need = (32'(bytes) + PAGE_SZ - 1) / PAGE_SZ;
                if (need != 0 && need <= PAGES) begin
                    for (p = 0; p < PAGES && !found; p++) begin
                        if (!page_used[p]) begin
                            run++;
                            if (run == need) begin
                                found = 1'b1;
                                first = p + 1 - need;
                            end
                        end else begin
                            run = 0;
                        end
                    end
                end
                if (found) begin
                    for (p = first; p < first + need; p++)
                        page_used[p] = 1'b1;
                    r.base = 10'(first * PAGE_SZ);
                    r.touched = 5'(need);
                end else begin
                    r.status = ST_NOSPACE;
                end
            end
            CMD_FREE: begin
                if (32'(offset) >= MEM_BYTES) begin
                    r.status = ST_OOB;
                end else begin
                    // The walk stops at the first free page, so it may run into a neighbor.
                    for (p = offset / PAGE_SZ; p < PAGES && page_used[p]; p++) begin
                        page_used[p] = 1'b0;
                        r.touched++;
                    end
                end
            end
            CMD_CLEAR: begin
                r.touched = 5'($countones(page_used));
                page_used = '0;
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // Called at a falling edge; returns at a falling edge with start left high
    // when the next transaction follows at once.
    task automatic send_request(input logic [1:0] cmd, input logic [15:0] bytes,
                                input logic [15:0] offset);
        int gap;
        i_cmd <= cmd;
        i_request_bytes <= bytes;
        i_release_offset <= offset;
        start <= 1'b1;
        do
            @(posedge i_clk);
        while (busy);
        pending_results.push_back(apply_page_request(cmd, bytes, offset));
        @(negedge i_clk);
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // Mostly allocations and frees that land inside used pages, so the map keeps churning.
    task automatic send_random_wellformed();
        int          r;
        int          s;
        int          p;
        int          k;
        logic [15:0] bytes;
        logic [15:0] offset;
        r = $urandom_range(0, 99);
        bytes = 16'($urandom);
        offset = 16'($urandom);
        if (r < 55) begin
            s = $urandom_range(0, 19);
            if (s < 11)
                bytes = 16'($urandom_range(1, 256));
            else if (s < 15)
                bytes = 16'(PAGE_SZ * $urandom_range(1, 8));
            else if (s < 18)
                bytes = 16'($urandom_range(1, MEM_BYTES));
            else if (s < 19)
                bytes = 16'($urandom_range(MEM_BYTES + 1, 65535));
            else
                bytes = '0;
            send_request(CMD_ALLOC, bytes, offset);
        end else if (r < 93) begin
            if ($urandom_range(0, 19) == 0) begin
                offset = 16'($urandom_range(MEM_BYTES, 65535));
            end else begin
                p = $urandom_range(0, PAGES - 1);
                for (k = 0; k < PAGES && !page_used[p]; k++)
                    p = (p + 1) % PAGES;
                offset = 16'(p * PAGE_SZ + $urandom_range(0, PAGE_SZ - 1));
            end
            send_request(CMD_FREE, bytes, offset);
        end else if (r < 97) begin
            send_request(CMD_CLEAR, bytes, offset);
        end else begin
            send_request(CMD_UNUSED, bytes, offset);
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_page_result want;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with no pending request, status", o_status, 0);
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status)
                    report_mismatch("status", o_status, want.status);
                if (o_base_offset !== want.base)
                    report_mismatch("base_offset", o_base_offset, want.base);
                if (o_pages_touched !== want.touched)
                    report_mismatch("pages_touched", o_pages_touched, want.touched);
            end
        end
    end

    task automatic test_allocate_edges();
        send_request(CMD_ALLOC, 16'd0, 16'd0);
        send_request(CMD_ALLOC, 16'd1, 16'hFFFF);
        send_request(CMD_ALLOC, 16'd64, 16'd0);
        send_request(CMD_ALLOC, 16'd65, 16'd0);
        send_request(CMD_ALLOC, 16'hFFFF, 16'd0);
        send_request(CMD_ALLOC, 16'd1025, 16'd0);
        send_request(CMD_ALLOC, 16'd768, 16'd0);
        // The map is now full, so even one byte finds no run.
        send_request(CMD_ALLOC, 16'd1, 16'd0);
    endtask

    task automatic test_free_edges();
        send_request(CMD_FREE, 16'd0, 16'd1024);
        send_request(CMD_FREE, 16'hFFFF, 16'hFFFF);
        send_request(CMD_FREE, 16'd0, 16'd69);
        send_request(CMD_FREE, 16'd0, 16'd64);
        send_request(CMD_FREE, 16'd0, 16'd0);
        send_request(CMD_ALLOC, 16'd1024, 16'd0);
        send_request(CMD_FREE, 16'd0, 16'd1023);
        send_request(CMD_ALLOC, 16'd128, 16'd0);
        send_request(CMD_ALLOC, 16'd64, 16'd0);
    endtask

    task automatic test_clear_and_unused();
        send_request(CMD_UNUSED, 16'hFFFF, 16'hFFFF);
        send_request(CMD_CLEAR, 16'd0, 16'd0);
        send_request(CMD_CLEAR, 16'hFFFF, 16'hFFFF);
        send_request(CMD_ALLOC, 16'h8000, 16'd0);
        send_request(CMD_ALLOC, 16'd1024, 16'd0);
        send_request(CMD_FREE, 16'd0, 16'd512);
        send_request(CMD_UNUSED, 16'd0, 16'd0);
    endtask

    task automatic test_churn();
        repeat (600) send_random_wellformed();
    endtask

    task automatic test_streaming();
        no_gaps = 1'b1;
        repeat (200) send_random_wellformed();
        no_gaps = 1'b0;
    endtask

    task automatic test_noise();
        repeat (100)
            send_request(2'($urandom_range(0, 3)), 16'($urandom), 16'($urandom));
    endtask

    initial begin
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_allocate_edges();
        test_free_edges();
        test_clear_and_unused();
        test_churn();
        test_streaming();
        test_noise();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (2 * PAGES + 8) @(posedge i_clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/fpa_pkg.sv
rtl/fpa_map.sv
rtl/first_fit_page_allocator_top.sv
test/first_fit_page_allocator_top_test.sv
